// ===== sv/hhfc_pkg.sv =====
`default_nettype none
package hhfc_pkg;

    localparam logic [7:0] SYNC0 = 8'h05;
    localparam logic [7:0] SYNC1 = 8'h0B;
    localparam logic [7:0] SYNC2 = 8'h7F;

    localparam logic [1:0] VERDICT_MORE = 2'd0;
    localparam logic [1:0] VERDICT_GOOD = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT0   = 5'b00001,
        PH_HUNT1   = 5'b00010,
        PH_HUNT2   = 5'b00100,
        PH_HEADER  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // One queued command: a payload beat or a zero-length frame marker.
    typedef struct packed {
        logic [7:0]  data;
        logic        has_byte;
        logic        last;
        logic [15:0] expected;
    } t_cmd;

    // A character that is not a hex digit passes through with its raw value.
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'd48 && c < 8'd58) begin
            v = c - 8'd48;
        end else if (c >= 8'd97 && c < 8'd103) begin
            v = c - 8'd87;
        end else if (c >= 8'd65 && c < 8'd71) begin
            v = c - 8'd55;
        end else begin
            v = c;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hhfc_front.sv =====
`default_nettype none
module hhfc_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire  [7:0]       i_rx_byte,
    output logic             o_push,
    output hhfc_pkg::t_cmd   o_cmd
);

    hhfc_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_length, n_length;
    logic [15:0] r_left, n_left;

    logic [15:0] w_shifted;
    logic [15:0] w_part;
    logic [4:0]  w_shamt;
    logic [15:0] w_len_final;
    logic [15:0] w_left_dec;

    assign w_shamt     = 5'd12 - {1'b0, r_hdr_cnt[1:0], 2'b00};
    assign w_shifted   = {8'd0, hhfc_pkg::hex_value(i_rx_byte)} << w_shamt;
    assign w_part      = w_shifted;
    assign w_len_final = r_length | w_part;
    assign w_left_dec  = r_left - 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_expected = r_expected;
        n_length   = r_length;
        n_left     = r_left;
        o_push     = 1'b0;
        o_cmd      = '{data: 8'd0, has_byte: 1'b0, last: 1'b0, expected: r_expected};
        if (i_accept) begin
            unique case (r_phase)
                hhfc_pkg::PH_HUNT1: begin
                    if (i_rx_byte == hhfc_pkg::SYNC1) begin
                        n_phase = hhfc_pkg::PH_HUNT2;
                    end else if (i_rx_byte == hhfc_pkg::SYNC0) begin
                        n_phase = hhfc_pkg::PH_HUNT1;
                    end else begin
                        n_phase = hhfc_pkg::PH_HUNT0;
                    end
                end
                hhfc_pkg::PH_HUNT2: begin
                    if (i_rx_byte == hhfc_pkg::SYNC2) begin
                        n_phase    = hhfc_pkg::PH_HEADER;
                        n_hdr_cnt  = 3'd0;
                        n_expected = 16'd0;
                        n_length   = 16'd0;
                    end else if (i_rx_byte == hhfc_pkg::SYNC0) begin
                        n_phase = hhfc_pkg::PH_HUNT1;
                    end else begin
                        n_phase = hhfc_pkg::PH_HUNT0;
                    end
                end
                hhfc_pkg::PH_HEADER: begin
                    if (!r_hdr_cnt[2]) begin
                        n_expected = r_expected | w_part;
                    end else begin
                        n_length = w_len_final;
                    end
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    if (r_hdr_cnt == 3'd7) begin
                        // The checksum digits are complete by now.
                        if (w_len_final == 16'd0) begin
                            o_push         = 1'b1;
                            o_cmd.last     = 1'b1;
                            n_phase        = hhfc_pkg::PH_HUNT0;
                        end else begin
                            n_left  = w_len_final;
                            n_phase = hhfc_pkg::PH_PAYLOAD;
                        end
                    end
                end
                hhfc_pkg::PH_PAYLOAD: begin
                    o_push         = 1'b1;
                    o_cmd.data     = i_rx_byte;
                    o_cmd.has_byte = 1'b1;
                    n_left         = w_left_dec;
                    if (w_left_dec == 16'd0) begin
                        o_cmd.last = 1'b1;
                        n_phase    = hhfc_pkg::PH_HUNT0;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == hhfc_pkg::SYNC0) ? hhfc_pkg::PH_HUNT1
                                                             : hhfc_pkg::PH_HUNT0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hhfc_pkg::PH_HUNT0;
            r_hdr_cnt  <= 3'd0;
            r_expected <= 16'd0;
            r_length   <= 16'd0;
            r_left     <= 16'd0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_expected <= n_expected;
            r_length   <= n_length;
            r_left     <= n_left;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hhfc_queue.sv =====
`default_nettype none
module hhfc_queue #(
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  hhfc_pkg::t_cmd   i_cmd,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output hhfc_pkg::t_cmd   o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hhfc_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hhfc_back.sv =====
`default_nettype none
module hhfc_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_valid,
    input  hhfc_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    input  wire              i_stall,
    output logic             o_valid,
    output logic [7:0]       o_payload_byte,
    output logic             o_has_byte,
    output logic             o_frame_end,
    output logic [1:0]       o_verdict
);

    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_has;
    logic        r_end;
    logic [1:0]  r_verdict;
    logic [15:0] r_sum, n_sum;
    logic [15:0] w_sum_add;

    assign o_pop     = i_cmd_valid && (!r_valid || !i_stall);
    assign w_sum_add = r_sum + {8'd0, i_cmd.data};

    // The sum restarts after every frame end, so a marker sees zero.
    always_comb begin
        n_sum = r_sum;
        if (o_pop) begin
            n_sum = i_cmd.last ? 16'd0 : w_sum_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= 16'd0;
        end else begin
            r_sum <= n_sum;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= i_cmd.data;
            r_has  <= i_cmd.has_byte;
            r_end  <= i_cmd.last;
            if (!i_cmd.last) begin
                r_verdict <= hhfc_pkg::VERDICT_MORE;
            end else if (w_sum_add == i_cmd.expected) begin
                r_verdict <= hhfc_pkg::VERDICT_GOOD;
            end else begin
                r_verdict <= hhfc_pkg::VERDICT_BAD;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_byte;
    assign o_has_byte     = r_has;
    assign o_frame_end    = r_end;
    assign o_verdict      = r_verdict;

endmodule
`default_nettype wire

// ===== sv/hex_header_frame_checker.sv =====
// Throughput: one input byte per cycle, sustained while the output side keeps up.
// A result beat reaches o_valid via the command queue and then the output register.
// Sync and header bytes produce no beat, but the last header digit of a zero-length
// frame yields the marker beat; input stalls only while the queue is full.
// Reset is synchronous and active low; it returns the parser to sync hunting and
// empties the queue and the output register.
`default_nettype none
module hex_header_frame_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_byte,
    output logic        o_frame_end,
    output logic [1:0]  o_verdict
);

    logic           w_accept;
    logic           w_push;
    hhfc_pkg::t_cmd w_push_cmd;
    logic           w_full;
    logic           w_q_valid;
    hhfc_pkg::t_cmd w_q_cmd;
    logic           w_pop;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    hhfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    hhfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    hhfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_frame_end    (o_frame_end),
        .o_verdict      (o_verdict)
    );

endmodule
`default_nettype wire

// ===== sv/hhfc_checker.sv =====
`default_nettype none
module hhfc_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        o_valid,
    input  wire        i_stall,
    input  wire  [7:0] o_payload_byte,
    input  wire        o_has_byte,
    input  wire        o_frame_end,
    input  wire  [1:0] o_verdict
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte) && $stable(o_verdict)
            && $stable(o_has_byte) && $stable(o_frame_end))
        else $error("stalled result beat changed");

    // A beat without a byte is only ever the zero-length frame marker.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_frame_end && o_payload_byte == 8'd0)
        else $error("marker beat malformed");

    // Only the final beat of a frame carries a verdict.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> o_verdict == hhfc_pkg::VERDICT_MORE)
        else $error("verdict on a non-final beat");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |->
            o_verdict == hhfc_pkg::VERDICT_GOOD || o_verdict == hhfc_pkg::VERDICT_BAD)
        else $error("frame end without a verdict");

endmodule

bind hex_header_frame_checker hhfc_checker u_hhfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_payload_byte (o_payload_byte),
    .o_has_byte     (o_has_byte),
    .o_frame_end    (o_frame_end),
    .o_verdict      (o_verdict)
);
`default_nettype wire
